@@ sv/assert_macros.svh @@
// Assertion macros used by the RTL top module
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising edge outside reset
`define CSO_ASSERT(label, clk_s, rst_s, prop, msg) \
  label: assert property (@(posedge clk_s) disable iff (rst_s) prop) else $error(msg);

// Same-cycle implication
`define CSO_ASSERT_IMPL(label, clk_s, rst_s, ante, cons, msg) \
  `CSO_ASSERT(label, clk_s, rst_s, (ante) |-> (cons), msg)

// Next-cycle implication
`define CSO_ASSERT_NEXT(label, clk_s, rst_s, ante, cons, msg) \
  `CSO_ASSERT(label, clk_s, rst_s, (ante) |=> (cons), msg)

`endif

@@ sv/cso_pkg.sv @@
// Types and constants of the capsule-sphere overlap test
package cso_pkg;

  localparam int RAD_BITS  = 22;
  localparam int RSUM_BITS = RAD_BITS + 1;
  localparam int CFG_IDX_BITS = 2;

  // Reset sphere: centre x = 30.0, radius = 12.0 (integer parts)
  localparam int RESET_SPHERE_X_INT = 30;
  localparam int RESET_SPHERE_R_INT = 12;

  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_SPHERE_X      = 2'd0,
    REG_SPHERE_Y      = 2'd1,
    REG_SPHERE_Z      = 2'd2,
    REG_SPHERE_RADIUS = 2'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    REGION_BOTTOM   = 2'd0,
    REGION_INTERIOR = 2'd1,
    REGION_TOP      = 2'd2
  } region_t;

  // Load enables of the two stages of the split multiplier
  typedef struct packed {
    logic part;
    logic sum;
  } mul_en_t;

endpackage

@@ sv/cso_ifs.sv @@
// Stream and configuration interfaces of the capsule-sphere overlap test
interface cso_capsule_if import cso_pkg::*; #(
  parameter int COORD_BITS = 24
) ();
  logic                         valid;
  logic                         ready;
  logic signed [COORD_BITS-1:0] bottom_x;
  logic signed [COORD_BITS-1:0] bottom_y;
  logic signed [COORD_BITS-1:0] bottom_z;
  logic signed [COORD_BITS-1:0] top_x;
  logic signed [COORD_BITS-1:0] top_y;
  logic signed [COORD_BITS-1:0] top_z;
  logic        [RAD_BITS-1:0]   capsule_radius;

  modport source (
    output valid, bottom_x, bottom_y, bottom_z, top_x, top_y, top_z, capsule_radius,
    input  ready
  );
  modport sink (
    input  valid, bottom_x, bottom_y, bottom_z, top_x, top_y, top_z, capsule_radius,
    output ready
  );
endinterface

interface cso_result_if ();
  logic       valid;
  logic       ready;
  logic       hit;
  logic [1:0] region;

  modport source (output valid, hit, region, input ready);
  modport sink (input valid, hit, region, output ready);
endinterface

interface cso_cfg_if import cso_pkg::*; #(
  parameter int DATA_BITS = 24
) ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [DATA_BITS-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/cso_wide_mul.sv @@
// Two-stage unsigned multiplier built from four half-width partial products
module cso_wide_mul import cso_pkg::*; #(
  parameter int W = 52
) (
  input  logic           clk,
  input  mul_en_t        en,
  input  logic [W-1:0]   a,
  input  logic [W-1:0]   b,
  output logic [2*W-1:0] p
);

  localparam int H  = (W + 1) / 2;
  localparam int HI = W - H;

  logic [2*H-1:0]  pp_ll;
  logic [H+HI-1:0] pp_lh;
  logic [H+HI-1:0] pp_hl;
  logic [2*HI-1:0] pp_hh;

  // partial products
  always_ff @(posedge clk) begin
    if (en.part) begin
      pp_ll <= (2*H)'(a[H-1:0]) * (2*H)'(b[H-1:0]);
      pp_lh <= (H+HI)'(a[H-1:0]) * (H+HI)'(b[W-1:H]);
      pp_hl <= (H+HI)'(a[W-1:H]) * (H+HI)'(b[H-1:0]);
      pp_hh <= (2*HI)'(a[W-1:H]) * (2*HI)'(b[W-1:H]);
    end
  end

  // align and add
  always_ff @(posedge clk) begin
    if (en.sum) begin
      p <= (2*W)'(pp_ll)
         + ((2*W)'(pp_lh) << H)
         + ((2*W)'(pp_hl) << H)
         + ((2*W)'(pp_hh) << (2*H));
    end
  end

endmodule

@@ sv/capsule_sphere_overlap_test_top.sv @@
// Capsule against sphere overlap test, seven-stage pipeline.
// Throughput: one request per cycle while the output is not stalled; a stalled stage
// holds, empty stages ahead of it still fill.
// Reset (rst, synchronous): clears all stage valid bits and loads the sphere registers
// with centre (30.0, 0, 0) and radius 12.0; configuration writes are never stalled.
`include "assert_macros.svh"

module capsule_sphere_overlap_test_top import cso_pkg::*; #(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 8
) (
  input  logic            clk,
  input  logic            rst,
  cso_cfg_if.sink         cfg,
  cso_capsule_if.sink     capsule,
  cso_result_if.source    result
);

  // Widths: differences, squares, dot products, squared radius sum,
  // the common compare width and the unsigned magnitude width of the interior test.
  localparam int DW = COORD_BITS + 1;
  localparam int PW = 2 * DW;
  localparam int SW = PW + 2;
  localparam int RW = 2 * RSUM_BITS;
  localparam int CW = ((SW > RW) ? SW : RW) + 1;
  localparam int MW = CW - 1;
  localparam int NSTAGE = 7;

  localparam logic [COORD_BITS-1:0] RESET_X =
    COORD_BITS'(64'(RESET_SPHERE_X_INT) << FRAC_BITS);
  localparam logic [RAD_BITS-1:0] RESET_R =
    RAD_BITS'(64'(RESET_SPHERE_R_INT) << FRAC_BITS);

  // ---------------------------------------------------------------------------
  // Sphere registers
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] sphere_x;
  logic signed [COORD_BITS-1:0] sphere_y;
  logic signed [COORD_BITS-1:0] sphere_z;
  logic        [RAD_BITS-1:0]   sphere_radius;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      sphere_x      <= RESET_X;
      sphere_y      <= '0;
      sphere_z      <= '0;
      sphere_radius <= RESET_R;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SPHERE_X:      sphere_x      <= cfg.data[COORD_BITS-1:0];
        REG_SPHERE_Y:      sphere_y      <= cfg.data[COORD_BITS-1:0];
        REG_SPHERE_Z:      sphere_z      <= cfg.data[COORD_BITS-1:0];
        REG_SPHERE_RADIUS: sphere_radius <= cfg.data[RAD_BITS-1:0];
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // Pipeline control: a stage loads when it is empty or the stage after it loads.
  // ---------------------------------------------------------------------------
  logic [NSTAGE:1] valid_q;
  logic [NSTAGE:1] en;

  always_comb begin
    en[NSTAGE] = !valid_q[NSTAGE] || result.ready;
    for (int k = NSTAGE - 1; k >= 1; k--) begin
      en[k] = !valid_q[k] || en[k+1];
    end
  end

  assign capsule.ready = en[1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_q <= '0;
    end else begin
      if (en[1]) begin
        valid_q[1] <= capsule.valid;
      end
      for (int k = 2; k <= NSTAGE; k++) begin
        if (en[k]) begin
          valid_q[k] <= valid_q[k-1];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 1: segment and centre offsets, radius sum
  // ---------------------------------------------------------------------------
  logic signed [COORD_BITS-1:0] bot_c [3];
  logic signed [COORD_BITS-1:0] top_c [3];
  logic signed [COORD_BITS-1:0] sph_c [3];

  always_comb begin
    bot_c[0] = capsule.bottom_x;
    bot_c[1] = capsule.bottom_y;
    bot_c[2] = capsule.bottom_z;
    top_c[0] = capsule.top_x;
    top_c[1] = capsule.top_y;
    top_c[2] = capsule.top_z;
    sph_c[0] = sphere_x;
    sph_c[1] = sphere_y;
    sph_c[2] = sphere_z;
  end

  logic signed [DW-1:0]        s1_ab [3];
  logic signed [DW-1:0]        s1_ac [3];
  logic signed [DW-1:0]        s1_bc [3];
  logic        [RSUM_BITS-1:0] s1_rsum;

  always_ff @(posedge clk) begin
    if (en[1]) begin
      for (int k = 0; k < 3; k++) begin
        s1_ab[k] <= DW'(top_c[k]) - DW'(bot_c[k]);
        s1_ac[k] <= DW'(sph_c[k]) - DW'(bot_c[k]);
        s1_bc[k] <= DW'(sph_c[k]) - DW'(top_c[k]);
      end
      s1_rsum <= RSUM_BITS'(capsule.capsule_radius) + RSUM_BITS'(sphere_radius);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 2: component products
  // ---------------------------------------------------------------------------
  logic signed [PW-1:0] s2_abab [3];
  logic signed [PW-1:0] s2_acab [3];
  logic signed [PW-1:0] s2_acac [3];
  logic signed [PW-1:0] s2_bcbc [3];
  logic        [RW-1:0] s2_r2;

  always_ff @(posedge clk) begin
    if (en[2]) begin
      for (int k = 0; k < 3; k++) begin
        s2_abab[k] <= PW'(s1_ab[k]) * PW'(s1_ab[k]);
        s2_acab[k] <= PW'(s1_ac[k]) * PW'(s1_ab[k]);
        s2_acac[k] <= PW'(s1_ac[k]) * PW'(s1_ac[k]);
        s2_bcbc[k] <= PW'(s1_bc[k]) * PW'(s1_bc[k]);
      end
      s2_r2 <= RW'(s1_rsum) * RW'(s1_rsum);
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 3: dot products L = |AB|^2, t = AC.AB, |AC|^2, |BC|^2
  // ---------------------------------------------------------------------------
  logic signed [SW-1:0] s3_len;
  logic signed [SW-1:0] s3_t;
  logic signed [SW-1:0] s3_ac2;
  logic signed [SW-1:0] s3_bc2;
  logic        [RW-1:0] s3_r2;

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_len <= SW'(s2_abab[0]) + SW'(s2_abab[1]) + SW'(s2_abab[2]);
      s3_t   <= SW'(s2_acab[0]) + SW'(s2_acab[1]) + SW'(s2_acab[2]);
      s3_ac2 <= SW'(s2_acac[0]) + SW'(s2_acac[1]) + SW'(s2_acac[2]);
      s3_bc2 <= SW'(s2_bcbc[0]) + SW'(s2_bcbc[1]) + SW'(s2_bcbc[2]);
      s3_r2  <= s2_r2;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 4: clamp decision and end-point tests.
  // The interior test |AC|^2*L - t^2 < R^2*L is rewritten as e*L < t^2 with
  // e = |AC|^2 - R^2; it always hits for e <= 0 since t > 0 there, so the wide
  // multiplier result e*L is only used when e is positive.
  // ---------------------------------------------------------------------------
  logic signed [CW-1:0] r2_c;
  logic signed [CW-1:0] e_c;
  logic signed [CW-1:0] f_c;
  logic                 t_pos;
  region_t              region_c;
  logic                 hit_end_c;

  always_comb begin
    r2_c  = $signed(CW'(s3_r2));
    e_c   = CW'(s3_ac2) - r2_c;
    f_c   = CW'(s3_bc2) - r2_c;
    t_pos = !s3_t[SW-1] && (s3_t != '0);
    if (!t_pos) begin
      region_c = REGION_BOTTOM;
    end else if (s3_t >= s3_len) begin
      region_c = REGION_TOP;
    end else begin
      region_c = REGION_INTERIOR;
    end
    hit_end_c = (region_c == REGION_TOP) ? f_c[CW-1] : e_c[CW-1];
  end

  region_t       s4_region;
  logic          s4_hit_end;
  logic          s4_e_pos;
  logic [MW-1:0] s4_e_mag;
  logic [MW-1:0] s4_len;
  logic [MW-1:0] s4_t;

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_region  <= region_c;
      s4_hit_end <= hit_end_c;
      s4_e_pos   <= !e_c[CW-1] && (e_c != '0);
      s4_e_mag   <= e_c[MW-1:0];
      s4_len     <= MW'(s3_len);
      s4_t       <= MW'(s3_t);
    end
  end

  // ---------------------------------------------------------------------------
  // Stages 5 and 6: e*L and t*t in split multipliers, side fields carried along
  // ---------------------------------------------------------------------------
  mul_en_t         mul_en;
  logic [2*MW-1:0] s6_el;
  logic [2*MW-1:0] s6_tt;

  assign mul_en.part = en[5];
  assign mul_en.sum  = en[6];

  cso_wide_mul #(.W(MW)) u_mul_el (
    .clk (clk),
    .en  (mul_en),
    .a   (s4_e_mag),
    .b   (s4_len),
    .p   (s6_el)
  );

  cso_wide_mul #(.W(MW)) u_mul_tt (
    .clk (clk),
    .en  (mul_en),
    .a   (s4_t),
    .b   (s4_t),
    .p   (s6_tt)
  );

  region_t s5_region;
  logic    s5_hit_end;
  logic    s5_e_pos;
  region_t s6_region;
  logic    s6_hit_end;
  logic    s6_e_pos;

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_region  <= s4_region;
      s5_hit_end <= s4_hit_end;
      s5_e_pos   <= s4_e_pos;
    end
    if (en[6]) begin
      s6_region  <= s5_region;
      s6_hit_end <= s5_hit_end;
      s6_e_pos   <= s5_e_pos;
    end
  end

  // ---------------------------------------------------------------------------
  // Stage 7: final compare into the output register
  // ---------------------------------------------------------------------------
  logic    s7_hit;
  region_t s7_region;

  always_ff @(posedge clk) begin
    if (en[7]) begin
      s7_region <= s6_region;
      if (s6_region == REGION_INTERIOR) begin
        s7_hit <= !s6_e_pos || (s6_el < s6_tt);
      end else begin
        s7_hit <= s6_hit_end;
      end
    end
  end

  assign result.valid  = valid_q[NSTAGE];
  assign result.hit    = s7_hit;
  assign result.region = s7_region;

  // ---------------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------------
  `CSO_ASSERT_NEXT(a_accept_enters, clk, rst, capsule.valid && capsule.ready, valid_q[1], "accepted request did not enter stage 1")
  `CSO_ASSERT_NEXT(a_s4_stall_holds, clk, rst, !en[4], valid_q[4] && $stable(s4_region) && $stable(s4_t), "stalled stage 4 changed")
  `CSO_ASSERT_IMPL(a_interior_inside, clk, rst, valid_q[4] && (s4_region == REGION_INTERIOR), (s4_t != '0) && (s4_t < s4_len), "interior region with projection outside the segment")
  `CSO_ASSERT_IMPL(a_ready_when_out_free, clk, rst, !result.valid, capsule.ready, "input stalled while output stage empty")

endmodule

@@ dv/capsule_sphere_overlap_test_top_tb.sv @@
// Self-checking testbench for the capsule-sphere overlap test pipeline
module capsule_sphere_overlap_test_top_tb;
  import cso_pkg::*;

  localparam int COORD_BITS = 24;
  localparam int FRAC_BITS  = 8;
  localparam int ONE        = 1 << FRAC_BITS;
  // Run limit in cycles: about 600 requests under both stall patterns, plus register
  // writes, allowed for many times over.
  localparam int CYCLE_LIMIT = 400000;
  // Cycles to hold after the last expected result; pipeline depth is 7.
  localparam int TAIL_CYCLES = 24;
  localparam int ITEMS_PER_SPHERE = 33;

  typedef logic [COORD_BITS-1:0] coord_t;
  typedef logic signed [159:0] wide_t;

  typedef struct packed {
    coord_t              bottom_x;
    coord_t              bottom_y;
    coord_t              bottom_z;
    coord_t              top_x;
    coord_t              top_y;
    coord_t              top_z;
    logic [RAD_BITS-1:0] capsule_radius;
  } capsule_t;

  typedef struct packed {
    logic    hit;
    region_t region;
  } overlap_t;

  logic clk;
  logic rst;

  cso_cfg_if #(.DATA_BITS(COORD_BITS)) cfg_ch ();
  cso_capsule_if #(.COORD_BITS(COORD_BITS)) capsule_ch ();
  cso_result_if result_ch ();

  capsule_sphere_overlap_test_top #(
    .COORD_BITS(COORD_BITS),
    .FRAC_BITS (FRAC_BITS)
  ) dut (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg_ch),
    .capsule(capsule_ch),
    .result (result_ch)
  );

  // Shadow copy of the sphere registers, updated when a write is accepted
  coord_t              sphere_x;
  coord_t              sphere_y;
  coord_t              sphere_z;
  logic [RAD_BITS-1:0] sphere_r;

  overlap_t expected_overlaps[$];

  int send_idle_pct;
  int recv_idle_pct;
  int cycle_count;
  int mismatch_count;
  int capsules_sent;
  int overlaps_checked;
  int hits_seen;
  int region_seen[3];
  int sphere_writes;

  // 20-unit clock period
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // Watchdog: end the run if the pipeline hangs
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still expected", cycle_count,
               expected_overlaps.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Result side stalls at random; a zero idle rate holds ready high.
  always @(negedge clk) begin
    result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  // Sign-extend a coordinate into the wide working type
  function automatic wide_t widen(coord_t v);
    return $signed(v);
  endfunction

  // Overlap predictor: exact integer distance test, no root or division.
  // Project the sphere centre onto the segment; t <= 0 (including a zero-length
  // segment) picks the bottom end, t >= |AB|^2 the top end, else the interior.
  function automatic overlap_t predict_overlap(capsule_t cap);
    wide_t    a[3];
    wide_t    b[3];
    wide_t    s[3];
    wide_t    ab[3];
    wide_t    ac[3];
    wide_t    bc[3];
    wide_t    seg_len2;
    wide_t    proj;
    wide_t    ac_dist2;
    wide_t    bc_dist2;
    wide_t    rsum;
    wide_t    rsum2;
    overlap_t r;
    a[0] = widen(cap.bottom_x);
    a[1] = widen(cap.bottom_y);
    a[2] = widen(cap.bottom_z);
    b[0] = widen(cap.top_x);
    b[1] = widen(cap.top_y);
    b[2] = widen(cap.top_z);
    s[0] = widen(sphere_x);
    s[1] = widen(sphere_y);
    s[2] = widen(sphere_z);
    for (int k = 0; k < 3; k++) begin
      ab[k] = b[k] - a[k];
      ac[k] = s[k] - a[k];
      bc[k] = s[k] - b[k];
    end
    seg_len2 = ab[0] * ab[0] + ab[1] * ab[1] + ab[2] * ab[2];
    proj     = ac[0] * ab[0] + ac[1] * ab[1] + ac[2] * ab[2];
    ac_dist2 = ac[0] * ac[0] + ac[1] * ac[1] + ac[2] * ac[2];
    bc_dist2 = bc[0] * bc[0] + bc[1] * bc[1] + bc[2] * bc[2];
    rsum     = $signed({138'd0, cap.capsule_radius}) + $signed({138'd0, sphere_r});
    rsum2    = rsum * rsum;
    if (proj <= 0) begin
      r.region = REGION_BOTTOM;
      r.hit    = (ac_dist2 < rsum2);
    end else if (proj >= seg_len2) begin
      r.region = REGION_TOP;
      r.hit    = (bc_dist2 < rsum2);
    end else begin
      r.region = REGION_INTERIOR;
      r.hit    = (ac_dist2 * seg_len2 - proj * proj < rsum2 * seg_len2);
    end
    return r;
  endfunction

  // Print one mismatch line and count it
  task automatic report_mismatch(string what, overlap_t got, overlap_t want);
    $display("mismatch at cycle %0d: %s (got hit=%0b region=%0d, want hit=%0b region=%0d)",
             cycle_count, what, got.hit, got.region, want.hit, want.region);
    mismatch_count++;
  endtask

  // Result checker: compare each accepted result with the oldest expectation
  always @(posedge clk) begin
    overlap_t got;
    overlap_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      got.hit    = result_ch.hit;
      got.region = region_t'(result_ch.region);
      if (expected_overlaps.size() == 0) begin
        report_mismatch("result with no request outstanding", got, got);
      end else begin
        want = expected_overlaps.pop_front();
        if (got.hit !== want.hit) begin
          report_mismatch("hit flag", got, want);
        end
        if (got.region !== want.region) begin
          report_mismatch("region", got, want);
        end
      end
      overlaps_checked++;
      if (got.hit === 1'b1) begin
        hits_seen++;
      end
      if (got.region < 3) begin
        region_seen[got.region]++;
      end
    end
  end

  // Send one capsule request. Entered at a falling edge; returns at the
  // falling edge after acceptance with valid still high, so back-to-back
  // requests never drop valid.
  task automatic send_capsule(capsule_t cap);
    while ($urandom_range(99) < send_idle_pct) begin
      capsule_ch.valid <= 1'b0;
      @(negedge clk);
    end
    capsule_ch.valid          <= 1'b1;
    capsule_ch.bottom_x       <= cap.bottom_x;
    capsule_ch.bottom_y       <= cap.bottom_y;
    capsule_ch.bottom_z       <= cap.bottom_z;
    capsule_ch.top_x          <= cap.top_x;
    capsule_ch.top_y          <= cap.top_y;
    capsule_ch.top_z          <= cap.top_z;
    capsule_ch.capsule_radius <= cap.capsule_radius;
    do @(posedge clk); while (!capsule_ch.ready);
    expected_overlaps.push_back(predict_overlap(cap));
    capsules_sent++;
    @(negedge clk);
  endtask

  // Drop the request valid and wait for every outstanding result.
  task automatic drain_pipeline();
    capsule_ch.valid <= 1'b0;
    @(negedge clk);
    while (expected_overlaps.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // Write one sphere register; valid stays high on return (see load_sphere).
  task automatic write_register(cfg_reg_t idx, logic [COORD_BITS-1:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    case (idx)
      REG_SPHERE_X:      sphere_x = value;
      REG_SPHERE_Y:      sphere_y = value;
      REG_SPHERE_Z:      sphere_z = value;
      REG_SPHERE_RADIUS: sphere_r = value[RAD_BITS-1:0];
      default: ;
    endcase
    sphere_writes++;
    @(negedge clk);
  endtask

  // Load a whole sphere while the pipeline is empty. The radius data is 24 bits
  // wide so the ignored upper bits get exercised too.
  task automatic load_sphere(int x, int y, int z, int radius);
    drain_pipeline();
    write_register(REG_SPHERE_X, COORD_BITS'(x));
    write_register(REG_SPHERE_Y, COORD_BITS'(y));
    write_register(REG_SPHERE_Z, COORD_BITS'(z));
    write_register(REG_SPHERE_RADIUS, COORD_BITS'(radius));
    cfg_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  // Build a capsule from raw fixed-point integers; bits above the width drop.
  function automatic capsule_t make_capsule(int ax, int ay, int az, int bx, int by, int bz,
                                            int radius);
    capsule_t c;
    c.bottom_x       = COORD_BITS'(ax);
    c.bottom_y       = COORD_BITS'(ay);
    c.bottom_z       = COORD_BITS'(az);
    c.top_x          = COORD_BITS'(bx);
    c.top_y          = COORD_BITS'(by);
    c.top_z          = COORD_BITS'(bz);
    c.capsule_radius = RAD_BITS'(radius);
    return c;
  endfunction

  // Offset a coordinate with wrap at the field width
  function automatic coord_t shift_coord(coord_t v, int offset);
    return COORD_BITS'(int'($signed(v)) + offset);
  endfunction

  function automatic coord_t near_coord(coord_t centre, int span);
    return shift_coord(centre, int'($urandom_range(2 * span)) - span);
  endfunction

  // Random capsule. Most requests land around the current sphere so that all
  // three regions and both hit outcomes show up; some sit exactly at touching
  // distance, some are zero-length, and the rest are raw random bits.
  function automatic capsule_t random_capsule();
    capsule_t c;
    int       span;
    int       pick;
    int       reach;
    int       radius;
    int       off_a;
    int       off_b;
    span = 3 * int'(sphere_r) + 4 * ONE;
    pick = $urandom_range(99);
    if (pick < 30) begin
      c.bottom_x       = COORD_BITS'($urandom);
      c.bottom_y       = COORD_BITS'($urandom);
      c.bottom_z       = COORD_BITS'($urandom);
      c.top_x          = COORD_BITS'($urandom);
      c.top_y          = COORD_BITS'($urandom);
      c.top_z          = COORD_BITS'($urandom);
      c.capsule_radius = RAD_BITS'($urandom);
    end else if (pick < 85) begin
      c.bottom_x       = near_coord(sphere_x, span);
      c.bottom_y       = near_coord(sphere_y, span);
      c.bottom_z       = near_coord(sphere_z, span);
      c.capsule_radius = RAD_BITS'($urandom_range(span));
      if (pick < 75) begin
        c.top_x = near_coord(sphere_x, span);
        c.top_y = near_coord(sphere_y, span);
        c.top_z = near_coord(sphere_z, span);
      end else begin
        // zero-length segment
        c.top_x = c.bottom_x;
        c.top_y = c.bottom_y;
        c.top_z = c.bottom_z;
      end
    end else begin
      // Nearest point at distance reach along x; radius sum equal or one LSB off
      reach  = int'(sphere_r) + int'($urandom_range(span));
      radius = reach - int'(sphere_r) + int'($urandom_range(2)) - 1;
      if (radius < 0) begin
        radius = 0;
      end
      off_a = int'($urandom_range(span, 1));
      off_b = int'($urandom_range(span, 1));
      c.bottom_x       = shift_coord(sphere_x, reach);
      c.bottom_z       = sphere_z;
      c.top_z          = sphere_z;
      c.capsule_radius = RAD_BITS'(radius);
      if ($urandom_range(1) == 0) begin
        // segment points away from the sphere: nearest point is the bottom end
        c.bottom_y = sphere_y;
        c.top_x    = shift_coord(sphere_x, reach + off_a);
        c.top_y    = sphere_y;
      end else begin
        // segment crosses the perpendicular foot: nearest point is interior
        c.bottom_y = shift_coord(sphere_y, -off_a);
        c.top_x    = c.bottom_x;
        c.top_y    = shift_coord(sphere_y, off_b);
      end
    end
    return c;
  endfunction

  // Special cases against the reset sphere (30, 0, 0), radius 12: zero-length
  // segments, projection exactly on either end, and exact touching distance
  // in every region (touching must not count as a hit, one LSB more must).
  task automatic test_special_cases();
    send_capsule(make_capsule(30*ONE, 0, 0, 30*ONE, 0, 0, 0));
    send_capsule(make_capsule(0, 0, 0, 0, 0, 0, 18*ONE));
    send_capsule(make_capsule(0, 0, 0, 0, 0, 0, 18*ONE + 1));
    // projection exactly on the bottom end
    send_capsule(make_capsule(0, 0, 0, 0, 10*ONE, 0, 18*ONE));
    send_capsule(make_capsule(0, 0, 0, 0, 10*ONE, 0, 18*ONE + 1));
    // projection exactly on the top end
    send_capsule(make_capsule(30*ONE, -10*ONE, 0, 30*ONE, 0, 0, 0));
    send_capsule(make_capsule(0, -10*ONE, 0, 0, 0, 0, 18*ONE));
    send_capsule(make_capsule(0, -10*ONE, 0, 0, 0, 0, 18*ONE + 1));
    // interior nearest point
    send_capsule(make_capsule(0, -10*ONE, 0, 0, 10*ONE, 0, 18*ONE));
    send_capsule(make_capsule(0, -10*ONE, 0, 0, 10*ONE, 0, 18*ONE + 1));
    send_capsule(make_capsule(30*ONE, -100*ONE, 0, 30*ONE, 100*ONE, 0, 0));
    // projection past the top end, clear miss
    send_capsule(make_capsule(0, 0, 0, 10*ONE, 0, 0, 0));
  endtask

  // Extremes of every input field
  task automatic test_field_extremes();
    int lo;
    int hi;
    int rmax;
    lo   = -(1 << (COORD_BITS - 1));
    hi   = (1 << (COORD_BITS - 1)) - 1;
    rmax = (1 << RAD_BITS) - 1;
    send_capsule(make_capsule(lo, lo, lo, hi, hi, hi, rmax));
    send_capsule(make_capsule(hi, hi, hi, lo, lo, lo, 0));
    send_capsule(make_capsule(hi, hi, hi, hi, hi, hi, rmax));
    send_capsule(make_capsule(lo, lo, lo, lo, lo, lo, 0));
    send_capsule(make_capsule(lo, hi, lo, hi, lo, hi, rmax));
    send_capsule(make_capsule(0, 0, 0, hi, 0, 0, 0));
  endtask

  // One idle pattern: walk through six sphere settings, the three scene spheres
  // and both corners of the register range, plus a random one.
  task automatic test_random_sweep(int send_pct, int recv_pct);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < 6; k++) begin
      case (k)
        0: load_sphere(30*ONE, 0, 0, 12*ONE);
        1: load_sphere(-30*ONE, 0, 0, 12*ONE);
        2: load_sphere(0, 0, 50*ONE, 24*ONE);
        3: load_sphere(32'h7F_FFFF, 32'h80_0000, 32'h7F_FFFF, 32'hFF_FFFF);
        4: load_sphere(32'h80_0000, 32'h7F_FFFF, 32'h80_0000, 0);
        default: load_sphere($urandom, $urandom, $urandom, $urandom);
      endcase
      for (int n = 0; n < ITEMS_PER_SPHERE; n++) begin
        send_capsule(random_capsule());
      end
    end
  endtask

  initial begin
    rst                       = 1'b1;
    cfg_ch.valid              = 1'b0;
    cfg_ch.index              = REG_SPHERE_X;
    cfg_ch.data               = '0;
    capsule_ch.valid          = 1'b0;
    capsule_ch.bottom_x       = '0;
    capsule_ch.bottom_y       = '0;
    capsule_ch.bottom_z       = '0;
    capsule_ch.top_x          = '0;
    capsule_ch.top_y          = '0;
    capsule_ch.top_z          = '0;
    capsule_ch.capsule_radius = '0;
    result_ch.ready           = 1'b0;
    send_idle_pct             = 0;
    recv_idle_pct             = 0;
    cycle_count               = 0;
    mismatch_count            = 0;
    capsules_sent             = 0;
    overlaps_checked          = 0;
    hits_seen                 = 0;
    sphere_writes             = 0;
    region_seen               = '{0, 0, 0};
    // Shadow registers start at the reset sphere
    sphere_x = COORD_BITS'(RESET_SPHERE_X_INT << FRAC_BITS);
    sphere_y = '0;
    sphere_z = '0;
    sphere_r = RAD_BITS'(RESET_SPHERE_R_INT << FRAC_BITS);

    // Hold reset, then release it on a falling edge
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Directed part runs on the reset sphere with the idle rates of the first sweep
    send_idle_pct = 29;
    recv_idle_pct = 48;
    test_special_cases();
    test_field_extremes();

    test_random_sweep(29, 48);
    test_random_sweep(48, 29);
    test_random_sweep(0, 0);

    // Wait out the last results, then keep the clock running to catch strays
    drain_pipeline();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("sent %0d capsules over %0d register writes; checked %0d results", capsules_sent,
             sphere_writes, overlaps_checked);
    $display("hits %0d; nearest point bottom %0d, interior %0d, top %0d", hits_seen,
             region_seen[0], region_seen[1], region_seen[2]);
    if (mismatch_count == 0 && expected_overlaps.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatch_count,
               expected_overlaps.size());
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+sv
sv/cso_pkg.sv
sv/cso_ifs.sv
sv/cso_wide_mul.sv
sv/capsule_sphere_overlap_test_top.sv
dv/capsule_sphere_overlap_test_top_tb.sv
